### rtl/tbrl_pkg.sv
// ----------------------------------------------------------------------------
// Token bucket rate limiter package
// Widths, reset values and arithmetic constants shared by the limiter
// and its checker.
// ----------------------------------------------------------------------------
package tbrl_pkg;

   // field and datapath widths
   localparam int ELAPSED_W = 32;
   localparam int RATE_W    = 32;
   localparam int PROD_W    = ELAPSED_W + RATE_W;
   localparam int LEVEL_W   = 39;
   localparam int CAP_W     = 29;

   // division by one million: drop six bits (divide by 64), then multiply
   // by a 54-bit reciprocal of 15625, split into 27-bit halves
   localparam int QX_LSB      = 6;
   localparam int QX_W        = 53;
   localparam int SAT_LSB     = QX_LSB + QX_W;
   localparam int HALF_W      = 27;
   localparam int XH_W        = QX_W - HALF_W;
   localparam int RECIP_W     = 54;
   localparam int RHI_W       = RECIP_W - HALF_W;
   localparam int RECIP_SHIFT = 67;
   localparam int PP_HH_W     = XH_W + RHI_W;
   localparam int PP_HL_W     = XH_W + HALF_W;
   localparam int PP_LH_W     = HALF_W + RHI_W;
   localparam int PP_LL_W     = 2 * HALF_W;
   localparam int MID_W       = 56;
   localparam int TOP_W       = PP_HH_W + HALF_W;
   localparam int GAIN_LSB    = RECIP_SHIFT - HALF_W;
   localparam int GAIN_W      = TOP_W - GAIN_LSB;
   localparam int SUM_W       = GAIN_W + 1;

   // input register, product, partial products, partial sum, quotient, result
   localparam int NUM_STAGES = 6;

   // arithmetic constants
   localparam logic [RECIP_W-1:0] RECIP_15625     = 54'd9444732965739291;
   localparam logic [RHI_W-1:0]   RECIP_HI        = RECIP_15625[RECIP_W-1:HALF_W];
   localparam logic [HALF_W-1:0]  RECIP_LO        = RECIP_15625[HALF_W-1:0];
   localparam logic [LEVEL_W-1:0] MILLI_PER_TOKEN = 39'd1000;
   localparam logic [9:0]         MILLI_FACTOR    = 10'd1000;
   localparam logic [RATE_W-1:0]  DIV10_RECIP     = 32'hCCCC_CCCD;
   localparam int                 DIV10_SHIFT     = 35;

   // reset values
   localparam logic [RATE_W-1:0]  RESET_RATE  = 32'd1000;
   localparam logic [CAP_W-1:0]   RESET_CAP   = 29'd101;
   localparam logic [LEVEL_W-1:0] RESET_LEVEL = 39'd101000;

   typedef logic [ELAPSED_W-1:0] elapsed_type;
   typedef logic [RATE_W-1:0]    rate_type;
   typedef logic [PROD_W-1:0]    prod_type;
   typedef logic [LEVEL_W-1:0]   level_type;
   typedef logic [GAIN_W-1:0]    gain_type;
   typedef logic [SUM_W-1:0]     sum_type;
   typedef logic [CAP_W-1:0]     cap_type;

endpackage

### rtl/token_bucket_rate_limiter.sv
// ----------------------------------------------------------------------------
// Token bucket rate limiter
// Milli-token bucket refilled by elapsed time times rate, one grant
// decision per request.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle while the output is not stalled and
// returns one response per request, in order. A request passes the input
// register, one 32x32 multiply of elapsed time and rate, the division by
// one million as a shift by six and a reciprocal multiply for 15625 (four
// partial products of the 26- and 27-bit halves, a partial sum, the
// quotient), and the result register, where the bucket level is refilled,
// capped and charged as it enters. Products too large for the reciprocal
// saturate the gain, which the cap absorbs. The pipeline closes up bubbles,
// so requests keep entering while a response waits, until every stage is
// full. A write to the rate register reaches the burst cap through
// cap_quo_ff and cap_ff; write it only while no request is in flight. Rate
// zero grants every request and leaves the level alone.
module token_bucket_rate_limiter
   import tbrl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // configuration
   input  logic                 csr_we,
   input  logic [RATE_W-1:0]    csr_wdata,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ELAPSED_W-1:0] req_elapsed_ns,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_granted,
   output logic [LEVEL_W-1:0]   rsp_level_millitokens
);

   localparam int OUT_STAGE = NUM_STAGES - 1;
   localparam int MILLI_W   = CAP_W + 11;

   // configuration and burst cap
   rate_type              rate_ff;
   logic [2*RATE_W-1:0]   cap_prod;
   cap_type               cap_quo_ff;
   level_type             cap_ff;
   logic [CAP_W:0]        cap_tokens;
   logic [MILLI_W-1:0]    cap_milli;

   // pipeline control
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] adv;

   // input and product stages
   elapsed_type           elapsed_ff;
   prod_type              prod_ff;
   logic                  prod_zero_ff;

   // quotient by reciprocal multiplication
   logic [QX_W-1:0]       qx;
   logic [XH_W-1:0]       qx_hi;
   logic [HALF_W-1:0]     qx_lo;
   logic [PP_HH_W-1:0]    pp_hh_ff;
   logic [PP_HL_W-1:0]    pp_hl_ff;
   logic [PP_LH_W-1:0]    pp_lh_ff;
   logic [PP_LL_W-1:0]    pp_ll_ff;
   logic                  pp_sat_ff;
   logic                  pp_zero_ff;
   logic [MID_W-1:0]      mid_in;
   logic [MID_W-1:0]      mid_ff;
   logic [PP_HH_W-1:0]    mid_hh_ff;
   logic                  mid_sat_ff;
   logic                  mid_zero_ff;
   logic [TOP_W-1:0]      top;
   gain_type              gain_ff;
   logic                  gain_zero_ff;

   // bucket and result
   level_type             level_ff;
   level_type             level_in;
   logic                  granted_in;
   logic                  granted_ff;
   level_type             rsp_level_ff;
   sum_type               sum;
   level_type             capped;

   // rate register and a registered cap update: rate / 10 by reciprocal, plus one, in milli-tokens
   assign cap_prod   = (2*RATE_W)'(rate_ff) * (2*RATE_W)'(DIV10_RECIP);
   assign cap_tokens = {1'b0, cap_quo_ff} + {{CAP_W{1'b0}}, 1'b1};
   assign cap_milli  = MILLI_W'(cap_tokens) * MILLI_W'(MILLI_FACTOR);

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff    <= RESET_RATE;
         cap_quo_ff <= RESET_CAP - {{(CAP_W-1){1'b0}}, 1'b1};
         cap_ff     <= RESET_LEVEL;
      end else begin
         if (csr_we) begin
            rate_ff <= csr_wdata;
         end
         cap_quo_ff <= cap_prod[DIV10_SHIFT +: CAP_W];
         cap_ff     <= cap_milli[LEVEL_W-1:0];
      end
   end

   // stall chain: a stage moves when it is empty or the next one moves
   always_comb begin
      adv[OUT_STAGE] = !valid_ff[OUT_STAGE] || rsp_ready;
      for (int i = OUT_STAGE - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign req_ready = adv[0];

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         elapsed_ff <= req_elapsed_ns;
      end
   end

   // elapsed times rate
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         prod_ff      <= PROD_W'(elapsed_ff) * PROD_W'(rate_ff);
         prod_zero_ff <= (rate_ff == '0);
      end
   end

   // product over 64 split in halves, times the reciprocal halves
   assign qx    = prod_ff[QX_LSB +: QX_W];
   assign qx_hi = qx[QX_W-1:HALF_W];
   assign qx_lo = qx[HALF_W-1:0];

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         pp_hh_ff   <= PP_HH_W'(qx_hi) * PP_HH_W'(RECIP_HI);
         pp_hl_ff   <= PP_HL_W'(qx_hi) * PP_HL_W'(RECIP_LO);
         pp_lh_ff   <= PP_LH_W'(qx_lo) * PP_LH_W'(RECIP_HI);
         pp_ll_ff   <= PP_LL_W'(qx_lo) * PP_LL_W'(RECIP_LO);
         pp_sat_ff  <= |prod_ff[PROD_W-1:SAT_LSB];
         pp_zero_ff <= prod_zero_ff;
      end
   end

   // middle partial products plus the carry part of the low one
   assign mid_in = {{(MID_W-PP_HL_W){1'b0}}, pp_hl_ff}
                 + {{(MID_W-PP_LH_W){1'b0}}, pp_lh_ff}
                 + {{(MID_W-HALF_W){1'b0}}, pp_ll_ff[PP_LL_W-1:HALF_W]};

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         mid_ff      <= mid_in;
         mid_hh_ff   <= pp_hh_ff;
         mid_sat_ff  <= pp_sat_ff;
         mid_zero_ff <= pp_zero_ff;
      end
   end

   // quotient from the top bits, saturated past the reciprocal range
   assign top = {mid_hh_ff, {HALF_W{1'b0}}} + {{(TOP_W-MID_W){1'b0}}, mid_ff};

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         gain_ff      <= mid_sat_ff ? '1 : top[TOP_W-1:GAIN_LSB];
         gain_zero_ff <= mid_zero_ff;
      end
   end

   // refill, cap at the burst size and take one token if there is one (rate zero leaves the level alone)
   assign sum       = {{(SUM_W-LEVEL_W){1'b0}}, level_ff} + {1'b0, gain_ff};
   assign capped    = (sum > {{(SUM_W-LEVEL_W){1'b0}}, cap_ff}) ? cap_ff
                                                                 : sum[LEVEL_W-1:0];

   always_comb begin
      if (gain_zero_ff) begin
         level_in   = level_ff;
         granted_in = 1'b1;
      end else if (capped >= MILLI_PER_TOKEN) begin
         level_in   = capped - MILLI_PER_TOKEN;
         granted_in = 1'b1;
      end else begin
         level_in   = capped;
         granted_in = 1'b0;
      end
   end

   // bucket level, updated as a request enters the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= RESET_LEVEL;
      end else if (adv[OUT_STAGE] && valid_ff[OUT_STAGE-1]) begin
         level_ff <= level_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (adv[OUT_STAGE]) begin
         granted_ff   <= granted_in;
         rsp_level_ff <= level_in;
      end
   end

   assign rsp_valid             = valid_ff[OUT_STAGE];
   assign rsp_granted           = granted_ff;
   assign rsp_level_millitokens = rsp_level_ff;

endmodule

### rtl/tbrl_checker.sv
// ----------------------------------------------------------------------------
// Token bucket rate limiter checker
// Port-level assertions on the limiter, attached by a bind statement.
// ----------------------------------------------------------------------------
module tbrl_checker
   import tbrl_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 csr_we,
   input logic [RATE_W-1:0]    csr_wdata,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic [ELAPSED_W-1:0] req_elapsed_ns,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_granted,
   input logic [LEVEL_W-1:0]   rsp_level_millitokens
);

   // no response right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted)
                                  && $stable(rsp_level_millitokens))
      else $error("stalled response changed");

   // an empty output means the pipeline can take a request
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with empty output");

   // a throttled request leaves less than one token
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> rsp_level_millitokens < MILLI_PER_TOKEN)
      else $error("throttled with a full token present");

endmodule

bind token_bucket_rate_limiter tbrl_checker u_tbrl_checker (.*);
